[design/svs_pkg.sv]
// Shared types and constants for the four-voice decaying square synth.
package svs_pkg;

  localparam int NUM_VOICES = 4;
  localparam int AMP_W      = 7;
  localparam int PER_W      = 7;
  localparam int DEC_W      = 17;
  localparam int MAG_W      = 6;
  localparam int PITCH_W    = 3;
  localparam int OFS_W      = 6;
  localparam int CFG_W      = 10;
  localparam int CFG_ADDR_W = 3;
  localparam int DUTY_W     = 10;
  localparam int SCALE_W    = 10;
  localparam int BASE_W     = 5;
  localparam int DIV_STEPS  = DEC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef logic signed [AMP_W-1:0] amp_t;
  typedef logic [PER_W-1:0]        per_t;
  typedef logic [DEC_W-1:0]        dec_t;
  typedef logic signed [1:0]       boost_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CENTER,
    CFG_SCALE,
    CFG_BASE,
    CFG_OFS_A,
    CFG_OFS_B,
    CFG_OFS_C,
    CFG_OFS_D
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_COMMIT,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic start;
    logic silence;
    logic step;
    logic commit;
  } lane_ctl_t;

  localparam logic [DUTY_W-1:0]  CENTER_RESET = 10'd50;
  localparam logic [SCALE_W-1:0] SCALE_RESET  = 10'd500;
  localparam logic [BASE_W-1:0]  BASE_RESET   = 5'd10;
  localparam logic [DUTY_W-1:0]  DUTY_MAX     = 10'd1023;

  localparam logic [OFS_W-1:0] OFFSET_RESET [NUM_VOICES] = '{6'd1, 6'd9, 6'd17, 6'd25};
  localparam logic signed [3:0] BOOST_FACTOR [NUM_VOICES] = '{4'sd6, 4'sd3, -4'sd3, -4'sd6};

endpackage

[design/svs_lane.sv]
// One voice lane: press detect, serial decay-interval divider, flip and decay counters.
module svs_lane import svs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  lane_ctl_t            ctl,
  input  logic                 key,
  input  logic [PITCH_W-1:0]   pitch,
  input  logic [OFS_W-1:0]     offset,
  input  logic [OFS_W-1:0]     offset_rst,
  input  logic [SCALE_W-1:0]   scale,
  input  amp_t                 amp_new,
  output amp_t                 amp
);

  per_t             period;
  per_t             pcount;
  dec_t             interval;
  dec_t             dcount;
  logic             held;
  logic             striking;
  logic [MAG_W-1:0] mag;
  dec_t             dq;
  logic [MAG_W-1:0] rem;

  logic             strike;
  per_t             per_new;
  logic [MAG_W:0]   r_shift;
  logic             r_ge;
  dec_t             interval_eff;
  amp_t             amp_next;
  per_t             pcount_next;
  dec_t             dcount_next;
  amp_t             amp_flip;

  assign strike  = ctl.start && key && !held;
  assign per_new = PER_W'({1'b0, offset}) + PER_W'(pitch);
  assign r_shift = {rem, dq[DEC_W-1]};
  assign r_ge    = (r_shift >= {1'b0, mag});

  always_comb begin
    interval_eff = interval;
    if (striking) begin
      interval_eff = (mag == '0) ? dec_t'(1) : dq;
    end
    amp_flip    = amp;
    pcount_next = '0;
    if (period != '0) begin
      pcount_next = pcount + per_t'(1);
      if (pcount_next == period) begin
        pcount_next = '0;
        amp_flip    = -amp;
      end
    end
    amp_next    = amp_flip;
    dcount_next = '0;
    if (interval_eff != '0) begin
      dcount_next = dcount + dec_t'(1);
      if (dcount_next == interval_eff) begin
        dcount_next = '0;
        if (amp_flip > 0) begin
          amp_next = amp_flip - amp_t'(1);
        end else if (amp_flip < 0) begin
          amp_next = amp_flip + amp_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amp      <= '0;
      period   <= PER_W'(offset_rst);
      pcount   <= '0;
      interval <= dec_t'(1);
      dcount   <= '0;
      held     <= 1'b0;
      striking <= 1'b0;
    end else begin
      if (ctl.start) begin
        held     <= key;
        striking <= strike;
        if (strike) begin
          period <= per_new;
          amp    <= amp_new;
          pcount <= '0;
          dcount <= '0;
        end
        if (ctl.silence) begin
          amp <= '0;
        end
      end
      if (ctl.commit) begin
        amp      <= amp_next;
        pcount   <= pcount_next;
        dcount   <= dcount_next;
        interval <= interval_eff;
        striking <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (strike) begin
      mag <= MAG_W'(amp_new < 0 ? -amp_new : amp_new);
      dq  <= DEC_W'(scale) * DEC_W'(per_new);
      rem <= '0;
    end else if (ctl.step) begin
      rem <= r_ge ? MAG_W'(r_shift - {1'b0, mag}) : MAG_W'(r_shift);
      dq  <= {dq[DEC_W-2:0], r_ge};
    end
  end

endmodule

[design/svs_mix.sv]
// Merge stage: center level plus the four voice amplitudes, clamped to the duty range.
module svs_mix import svs_pkg::*; (
  input  logic [DUTY_W-1:0] center,
  input  amp_t              amps [NUM_VOICES],
  output logic [DUTY_W-1:0] duty
);

  localparam int SUM_W = DUTY_W + 2;

  logic signed [SUM_W-1:0] sum;

  always_comb begin
    sum = $signed({2'b00, center});
    for (int i = 0; i < NUM_VOICES; i++) begin
      sum = sum + SUM_W'(amps[i]);
    end
    if (sum < 0) begin
      duty = '0;
    end else if (sum > $signed({2'b00, DUTY_MAX})) begin
      duty = DUTY_MAX;
    end else begin
      duty = DUTY_W'(sum);
    end
  end

endmodule

[design/four_voice_decaying_square_synth_unit.sv]
// Top level of the four-voice decaying square synth: control sequencer, config, lanes, output.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    key_pressed, raise_pressed, lower_pressed, pitch_a..d
//   out      output     out_valid/out_stall  duty, led_high, led_low
//   cfg      input      cfg_wr_en            cfg_addr, cfg_wr_data
//
// One tick runs through accept, 17 steps of the per-lane serial divider, commit and deliver.
// The divider computes one quotient bit per cycle and runs on every tick.
// Synchronous active-high reset clears the voice counters and amplitudes and restores register defaults.
// A result waits in the output register while the next tick is taken and worked on;
// that next tick then stalls in delivery until the output register frees.
module four_voice_decaying_square_synth_unit import svs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [NUM_VOICES-1:0] key_pressed,
  input  logic                  raise_pressed,
  input  logic                  lower_pressed,
  input  logic [PITCH_W-1:0]    pitch_a,
  input  logic [PITCH_W-1:0]    pitch_b,
  input  logic [PITCH_W-1:0]    pitch_c,
  input  logic [PITCH_W-1:0]    pitch_d,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DUTY_W-1:0]     duty,
  output logic                  led_high,
  output logic                  led_low,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wr_data
);

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [DUTY_W-1:0]  center;
  logic [SCALE_W-1:0] scale;
  logic [BASE_W-1:0]  base;
  logic [OFS_W-1:0]   offset [NUM_VOICES];

  boost_t boost;
  logic   raise_held;
  logic   lower_held;

  logic [DUTY_W-1:0] res_duty;
  logic              res_high;
  logic              res_low;

  logic               accept;
  logic               slot_free;
  lane_ctl_t          ctl;
  amp_t               amps [NUM_VOICES];
  amp_t               amp_new [NUM_VOICES];
  logic [PITCH_W-1:0] pitch [NUM_VOICES];
  logic [DUTY_W-1:0]  mix_duty;
  logic               raise_ev;
  logic               lower_ev;
  boost_t             boost_mid;
  boost_t             boost_next;
  logic signed [7:0]  bump;

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign pitch[0]  = pitch_a;
  assign pitch[1]  = pitch_b;
  assign pitch[2]  = pitch_c;
  assign pitch[3]  = pitch_d;

  always_comb begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      unique case (boost)
        2'sb01:  bump = 8'(BOOST_FACTOR[i]);
        2'sb11:  bump = -8'(BOOST_FACTOR[i]);
        default: bump = '0;
      endcase
      amp_new[i] = AMP_W'($signed({3'b000, base}) + bump);
    end
  end

  always_comb begin
    raise_ev   = raise_pressed && !raise_held && (boost < 2'sd1);
    boost_mid  = raise_ev ? boost + 2'sd1 : boost;
    lower_ev   = lower_pressed && !lower_held && (boost_mid > -2'sd1);
    boost_next = lower_ev ? boost_mid - 2'sd1 : boost_mid;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_DIVIDE;
      ST_DIVIDE:  if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_COMMIT;
      ST_COMMIT:  state_next = ST_DELIVER;
      ST_DELIVER: if (slot_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state != ST_IDLE);
    ctl.start   = accept;
    ctl.silence = accept && (raise_ev || lower_ev);
    ctl.step    = (state == ST_DIVIDE);
    ctl.commit  = (state == ST_COMMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= (state == ST_DIVIDE) ? div_cnt + DIV_CNT_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= CENTER_RESET;
      scale  <= SCALE_RESET;
      base   <= BASE_RESET;
      for (int i = 0; i < NUM_VOICES; i++) begin
        offset[i] <= OFFSET_RESET[i];
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_CENTER: center    <= cfg_wr_data;
        CFG_SCALE:  scale     <= cfg_wr_data;
        CFG_BASE:   base      <= cfg_wr_data[BASE_W-1:0];
        CFG_OFS_A:  offset[0] <= cfg_wr_data[OFS_W-1:0];
        CFG_OFS_B:  offset[1] <= cfg_wr_data[OFS_W-1:0];
        CFG_OFS_C:  offset[2] <= cfg_wr_data[OFS_W-1:0];
        CFG_OFS_D:  offset[3] <= cfg_wr_data[OFS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      boost      <= '0;
      raise_held <= 1'b0;
      lower_held <= 1'b0;
    end else if (accept) begin
      boost <= boost_next;
      if (raise_ev) begin
        raise_held <= 1'b1;
      end else if (!raise_pressed && raise_held) begin
        raise_held <= 1'b0;
      end
      if (lower_ev) begin
        lower_held <= 1'b1;
      end else if (!lower_pressed && lower_held) begin
        lower_held <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_duty <= mix_duty;
      res_high <= (boost == 2'sd1);
      res_low  <= (boost == -2'sd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DELIVER && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DELIVER && slot_free) begin
      duty     <= res_duty;
      led_high <= res_high;
      led_low  <= res_low;
    end
  end

  for (genvar g = 0; g < NUM_VOICES; g++) begin : g_lane
    svs_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key        (key_pressed[g]),
      .pitch      (pitch[g]),
      .offset     (offset[g]),
      .offset_rst (OFFSET_RESET[g]),
      .scale      (scale),
      .amp_new    (amp_new[g]),
      .amp        (amps[g])
    );
  end

  svs_mix u_mix (
    .center (center),
    .amps   (amps),
    .duty   (mix_duty)
  );

  a_accept_divides: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DIVIDE)
    else $error("accepted tick did not enter divide");

  a_boost_range: assert property (@(posedge clk) disable iff (rst)
    boost != 2'sb10)
    else $error("boost level out of range");

  a_leds_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(led_high && led_low))
    else $error("both boost leds set");

  a_deliver_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DELIVER && slot_free) |=> out_valid && state == ST_IDLE)
    else $error("delivery did not load output");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> div_cnt < DIV_CNT_W'(DIV_STEPS))
    else $error("divide counter overran");

endmodule
